### rtl/mhc_pkg.sv
// Package with shared constants and codes for the midpoint half-circle point generator.
package mhc_pkg;

   // default widths of the coordinate and radius fields
   localparam int COORD_BITS_DEF  = 12;
   localparam int RADIUS_BITS_DEF = 10;

   // width of the point count field
   localparam int COUNT_W = 3;

   // command codes
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // point counts carried by a result word
   localparam logic [COUNT_W-1:0] COUNT_NONE    = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_START   = 3'd1;
   localparam logic [COUNT_W-1:0] COUNT_ADVANCE = 3'd4;

endpackage

### rtl/mhc_ifs.sv
// Handshake interfaces for the command channel and the point channel.
interface mhc_req_if #(
   parameter int COORD_BITS  = mhc_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mhc_pkg::RADIUS_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [COORD_BITS-1:0]  center_x;
   logic signed [COORD_BITS-1:0]  center_y;
   logic        [RADIUS_BITS-1:0] radius;

   modport source (output valid, output cmd, output center_x, output center_y,
                   output radius, input ready);
   modport sink (input valid, input cmd, input center_x, input center_y,
                 input radius, output ready);
endinterface

interface mhc_rsp_if #(
   parameter int COORD_BITS = mhc_pkg::COORD_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic signed [COORD_BITS:0]       p0_x;
   logic signed [COORD_BITS:0]       p0_y;
   logic signed [COORD_BITS:0]       p1_x;
   logic signed [COORD_BITS:0]       p1_y;
   logic signed [COORD_BITS:0]       p2_x;
   logic signed [COORD_BITS:0]       p2_y;
   logic signed [COORD_BITS:0]       p3_x;
   logic signed [COORD_BITS:0]       p3_y;
   logic [mhc_pkg::COUNT_W-1:0]      point_count;
   logic                             done_res;

   modport source (output valid, output p0_x, output p0_y, output p1_x, output p1_y,
                   output p2_x, output p2_y, output p3_x, output p3_y,
                   output point_count, output done_res, input ready);
   modport sink (input valid, input p0_x, input p0_y, input p1_x, input p1_y,
                 input p2_x, input p2_y, input p3_x, input p3_y,
                 input point_count, input done_res, output ready);
endinterface

### rtl/midpoint_half_circle_points.sv
// An accepted command word's point word is registered and shown on rsp in the next cycle.
// Throughput: one command word per cycle; the output register drains while
// the next word is taken, so ready only drops when a held word is not taken.
// Each advance is one midpoint iteration done in the same cycle it is taken.
// Synchronous active-high reset: idle, no circle running, no word on rsp.
// Top level of the midpoint half-circle point generator.
module midpoint_half_circle_points #(
   parameter int COORD_BITS  = mhc_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mhc_pkg::RADIUS_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mhc_req_if.sink   req,
   mhc_rsp_if.source rsp
);
   logic signed [COORD_BITS:0]    pt_x [4];
   logic signed [COORD_BITS:0]    pt_y [4];
   logic [mhc_pkg::COUNT_W-1:0]   count;
   logic                          done;
   logic                          take;

   logic                          rsp_valid_ff;
   logic signed [COORD_BITS:0]    px_ff [4];
   logic signed [COORD_BITS:0]    py_ff [4];
   logic [mhc_pkg::COUNT_W-1:0]   count_ff;
   logic                          done_ff;

   // take a word when the output register is empty or being drained
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;

   mhc_tracker #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .cmd         (req.cmd),
      .center_x    (req.center_x),
      .center_y    (req.center_y),
      .radius      (req.radius),
      .pt_x        (pt_x),
      .pt_y        (pt_y),
      .point_count (count),
      .done_res    (done)
   );

   // hold the result word valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // load the result payload
   always_ff @(posedge clock) begin
      if (take) begin
         px_ff    <= pt_x;
         py_ff    <= pt_y;
         count_ff <= count;
         done_ff  <= done;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.p0_x        = px_ff[0];
   assign rsp.p0_y        = py_ff[0];
   assign rsp.p1_x        = px_ff[1];
   assign rsp.p1_y        = py_ff[1];
   assign rsp.p2_x        = px_ff[2];
   assign rsp.p2_y        = py_ff[2];
   assign rsp.p3_x        = px_ff[3];
   assign rsp.p3_y        = py_ff[3];
   assign rsp.point_count = count_ff;
   assign rsp.done_res    = done_ff;

endmodule

### rtl/mhc_tracker.sv
// Circle state registers, midpoint update and point computation for one word.
module mhc_tracker #(
   parameter int COORD_BITS  = mhc_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mhc_pkg::RADIUS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic                          cmd,
   input  logic signed [COORD_BITS-1:0]  center_x,
   input  logic signed [COORD_BITS-1:0]  center_y,
   input  logic        [RADIUS_BITS-1:0] radius,
   output logic signed [COORD_BITS:0]    pt_x [4],
   output logic signed [COORD_BITS:0]    pt_y [4],
   output logic [mhc_pkg::COUNT_W-1:0]   point_count,
   output logic                          done_res
);
   // output coordinate width, step width (room for y = -1), decision width
   localparam int OW = COORD_BITS + 1;
   localparam int SW = RADIUS_BITS + 2;
   localparam int DW = RADIUS_BITS + 4;

   logic signed [SW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [OW-1:0] org_x_ff, org_x_in, base_ff, base_in;
   logic                 running_ff, running_in;

   logic signed [SW-1:0] r_s, x_nx, y_nx;
   logic signed [DW-1:0] inc_a, inc_b;
   logic signed [OW-1:0] h_o, k_o, r_o, half_o, start_base, x_o, y_o;
   logic                 finish;

   // start values, coordinates kept modulo the output width
   always_comb begin
      r_s        = SW'($signed({1'b0, radius}));
      h_o        = OW'(center_x);
      k_o        = OW'(center_y);
      r_o        = OW'($signed({1'b0, radius}));
      half_o     = OW'($signed({1'b0, radius >> 1}));
      start_base = k_o - half_o;
   end

   // midpoint step on the held state
   always_comb begin
      inc_a  = (DW'(x_ff) <<< 1) + DW'(3);
      inc_b  = ((DW'(x_ff) - DW'(y_ff)) <<< 1) + DW'(5);
      x_nx   = x_ff + SW'(1);
      y_nx   = d_ff[DW-1] ? y_ff : y_ff - SW'(1);
      finish = x_nx > y_nx;
      x_o    = OW'(x_ff);
      y_o    = OW'(y_ff);
   end

   // points and next state for the word at the input
   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      d_in        = d_ff;
      org_x_in    = org_x_ff;
      base_in     = base_ff;
      running_in  = running_ff;
      pt_x        = '{default: '0};
      pt_y        = '{default: '0};
      point_count = mhc_pkg::COUNT_NONE;
      done_res    = 1'b0;
      priority if (cmd == mhc_pkg::CMD_START) begin
         x_in        = '0;
         y_in        = r_s;
         d_in        = DW'(1) - DW'($signed({1'b0, radius}));
         org_x_in    = h_o;
         base_in     = start_base;
         running_in  = 1'b1;
         pt_x[0]     = h_o;
         pt_y[0]     = r_o + start_base;
         point_count = mhc_pkg::COUNT_START;
      end else if (running_ff) begin
         pt_x[0]     = x_o + org_x_ff;
         pt_y[0]     = y_o + base_ff;
         pt_x[1]     = x_o + org_x_ff;
         pt_y[1]     = base_ff - y_o;
         pt_x[2]     = y_o + org_x_ff;
         pt_y[2]     = x_o + base_ff;
         pt_x[3]     = y_o + org_x_ff;
         pt_y[3]     = base_ff - x_o;
         point_count = mhc_pkg::COUNT_ADVANCE;
         done_res    = finish;
         x_in        = x_nx;
         y_in        = y_nx;
         d_in        = d_ff + (d_ff[DW-1] ? inc_a : inc_b);
         running_in  = !finish;
      end else begin
         // advance while idle: no points
         point_count = mhc_pkg::COUNT_NONE;
      end
   end

   // hold state, update on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff       <= '0;
         y_ff       <= '0;
         d_ff       <= '0;
         org_x_ff   <= '0;
         base_ff    <= '0;
         running_ff <= 1'b0;
      end else if (take) begin
         x_ff       <= x_in;
         y_ff       <= y_in;
         d_ff       <= d_in;
         org_x_ff   <= org_x_in;
         base_ff    <= base_in;
         running_ff <= running_in;
      end
   end

endmodule

### rtl/mhc_checker.sv
// Port-level assertions for the midpoint half-circle point generator, with bind.
module mhc_checker #(
   parameter int COORD_BITS = mhc_pkg::COORD_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_cmd,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [COORD_BITS:0]  rsp_p0_x,
   input logic signed [COORD_BITS:0]  rsp_p0_y,
   input logic [mhc_pkg::COUNT_W-1:0] rsp_point_count,
   input logic                        rsp_done_res
);

   // no word is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_p0_x) && $stable(rsp_p0_y)
         && $stable(rsp_point_count) && $stable(rsp_done_res))
      else $error("stalled rsp word changed");

   // a start gives one point and no done in the next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == mhc_pkg::CMD_START |=>
         rsp_valid && rsp_point_count == mhc_pkg::COUNT_START && !rsp_done_res)
      else $error("start word not answered with one point");

   // done only comes with a full advance
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_point_count == mhc_pkg::COUNT_ADVANCE)
      else $error("done without four points");

   // an empty word carries zero points
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_count == mhc_pkg::COUNT_NONE |->
         rsp_p0_x == '0 && rsp_p0_y == '0 && !rsp_done_res)
      else $error("idle advance carries data");

endmodule

bind midpoint_half_circle_points mhc_checker #(
   .COORD_BITS (COORD_BITS)
) u_mhc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_cmd         (req.cmd),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_p0_x        (rsp.p0_x),
   .rsp_p0_y        (rsp.p0_y),
   .rsp_point_count (rsp.point_count),
   .rsp_done_res    (rsp.done_res)
);
